@@ rtl/almtp_pkg.sv @@
// Shared types, widths and constants for the true peak level meter.
// Used by almtp_interp and audio_level_meter_true_peak_core; no dependencies.
`default_nettype none

package almtp_pkg;

   // Fixed field and state widths.
   localparam int SAMPLE_W  = 24;
   localparam int MAG_W     = 24;
   localparam int SQ_W      = 48;
   localparam int SSUM_W    = 64;
   localparam int IDX_W     = 12;
   localparam int BLEN_W    = 13;
   localparam int CHAN_W    = 4;
   localparam int COEFF_W   = 24;
   localparam int ONE_W     = 25;
   localparam int CLIP_W    = 20;
   localparam int TP_W      = 26;
   localparam int VU_W      = 32;
   localparam int DB_W      = 16;
   localparam int DIV_W     = 16;
   localparam int ROOT_W    = 32;
   localparam int SREM_W    = 34;
   localparam int MUL_W     = 32;
   localparam int INTERP_W  = 36;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 24;

   localparam int MAX_BLOCK_SAMPLES = 4096;
   localparam int MAX_CHANNELS      = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_COEFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VU_COEFF   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_HOLD  = 2'd2;

   localparam logic [COEFF_W-1:0] PEAK_COEFF_RESET = 24'd16776411;
   localparam logic [COEFF_W-1:0] VU_COEFF_RESET   = 24'd16771851;
   localparam logic [CLIP_W-1:0]  CLIP_HOLD_RESET  = 20'd72000;

   localparam logic [ONE_W-1:0]  Q24_ONE        = 25'h100_0000;
   localparam logic [TP_W-1:0]   TP_MAX         = '1;
   localparam logic [TP_W-1:0]   CLIP_THRESHOLD = 26'd8292584;
   localparam logic [MUL_W-1:0]  DB_SCALE_Q16   = 32'd101008905;
   localparam logic signed [DB_W-1:0] DB_FLOOR  = -16'sd25600;
   localparam logic signed [DB_W-1:0] DB_CEIL   = 16'sd1024;

   // Interpolation phase codes (t = 1/4, 1/2, 3/4).
   localparam logic [1:0] INTERP_T1 = 2'd1;
   localparam logic [1:0] INTERP_T2 = 2'd2;
   localparam logic [1:0] INTERP_T3 = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_of_channel;
      logic                       last_of_block;
   } req_payload_type;

   typedef struct packed {
      logic signed [DB_W-1:0] peak_level_db;
      logic signed [DB_W-1:0] true_peak_level_db;
      logic signed [DB_W-1:0] vu_level_db;
      logic [CLIP_W-1:0]      clip_hold_left;
   } rsp_payload_type;

   // Catmull-Rom segment coefficients and the phase to evaluate.
   typedef struct packed {
      logic signed [27:0]         a0;
      logic signed [27:0]         a1;
      logic signed [25:0]         a2;
      logic signed [SAMPLE_W-1:0] y1;
      logic [1:0]                 k;
   } seg_coef_type;

endpackage

`default_nettype wire

@@ rtl/almtp_interp.sv @@
// Evaluates one 4x Catmull-Rom interpolant and returns its rounded magnitude.
// Depends on almtp_pkg for the segment struct and widths.
`default_nettype none

module almtp_interp (
   input  almtp_pkg::seg_coef_type      seg_i,
   output logic [almtp_pkg::TP_W-1:0]   tp_mag_o
);
   import almtp_pkg::*;

   logic signed [INTERP_W-1:0] a0_x, a1_x, a2_x, y1_x;
   logic signed [INTERP_W-1:0] t0, t1, t2, v;
   logic [INTERP_W-1:0]        v_abs;
   logic [INTERP_W-8:0]        v_rnd;

   always_comb begin
      a0_x = INTERP_W'(seg_i.a0);
      a1_x = INTERP_W'(seg_i.a1);
      a2_x = INTERP_W'(seg_i.a2);
      y1_x = INTERP_W'(seg_i.y1);
      unique case (seg_i.k)
         INTERP_T1: begin
            t0 = a0_x;
            t1 = a1_x * 36'sd4;
            t2 = a2_x * 36'sd16;
         end
         INTERP_T2: begin
            t0 = a0_x * 36'sd8;
            t1 = a1_x * 36'sd16;
            t2 = a2_x * 36'sd32;
         end
         INTERP_T3: begin
            t0 = a0_x * 36'sd27;
            t1 = a1_x * 36'sd36;
            t2 = a2_x * 36'sd48;
         end
         default: begin
            t0 = '0;
            t1 = '0;
            t2 = '0;
         end
      endcase
      // Value in 1/128 sample units; round its magnitude half up.
      v        = t0 + t1 + t2 + (y1_x * 36'sd128);
      v_abs    = v[INTERP_W-1] ? $unsigned(-v) : $unsigned(v);
      v_rnd    = (INTERP_W-7)'((v_abs + INTERP_W'(64)) >> 7);
      tp_mag_o = (v_rnd > (INTERP_W-7)'(TP_MAX)) ? TP_MAX : TP_W'(v_rnd);
   end

endmodule

`default_nettype wire

@@ rtl/audio_level_meter_true_peak_core.sv @@
// Level meter: sample peak, 4x true peak, VU and clip hold, one result per block.
// A sample passes IDLE, SQ and ACC, then SEGA and SEGK for each segment.
// The last sample of a block adds the end-of-block work, which runs
// on one shared 32x32 multiplier and a restoring divider and square root.
// Synchronous active-high reset loads the default coefficients and clears state.
`default_nettype none

module audio_level_meter_true_peak_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  almtp_pkg::req_payload_type          req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output almtp_pkg::rsp_payload_type          rsp_data,
   input  wire                                 csr_we,
   input  wire [almtp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [almtp_pkg::CSR_W-1:0]          csr_wdata
);
   import almtp_pkg::*;

   // The sequencer. Each item walks IDLE -> SQ -> ACC, then through up to two
   // interpolation segments. The last item of a block continues through the
   // end-of-block sequence: the peak coefficient power, the peak update, the VU
   // coefficient power, the mean-square divide, the square root, the VU update and
   // three dB conversions, and finally hands the result to the output register.
   typedef enum logic [17:0] {
      ST_IDLE  = 18'h00001,
      ST_SQ    = 18'h00002,
      ST_ACC   = 18'h00004,
      ST_SEGA  = 18'h00008,
      ST_SEGK  = 18'h00010,
      ST_POWR  = 18'h00020,
      ST_POWB  = 18'h00040,
      ST_PEAK  = 18'h00080,
      ST_DIV   = 18'h00100,
      ST_SQRT  = 18'h00200,
      ST_VU1   = 18'h00400,
      ST_VU2   = 18'h00800,
      ST_DBLD  = 18'h01000,
      ST_DBNRM = 18'h02000,
      ST_DBSQ  = 18'h04000,
      ST_DBSC  = 18'h08000,
      ST_DONE  = 18'h10000,
      ST_SPARE = 18'h20000
   } state_type;

   localparam logic [1:0] DB_SEL_PEAK = 2'd0;
   localparam logic [1:0] DB_SEL_TP   = 2'd1;
   localparam logic [1:0] DB_SEL_VU   = 2'd2;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [COEFF_W-1:0] peak_coeff_ff, peak_coeff_in;
   logic [COEFF_W-1:0] vu_coeff_ff, vu_coeff_in;
   logic [CLIP_W-1:0]  clip_cfg_ff, clip_cfg_in;

   // Meter state; the envelopes, clip count and history survive from block to block.
   logic [MAG_W-1:0]           peak_env_ff, peak_env_in;
   logic [VU_W-1:0]            vu_env_ff, vu_env_in;
   logic [CLIP_W-1:0]          clip_cnt_ff, clip_cnt_in;
   logic signed [SAMPLE_W-1:0] hist0_ff, hist0_in, hist1_ff, hist1_in, hist2_ff, hist2_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [BLEN_W-1:0]          blk_len_ff, blk_len_in;
   logic [CHAN_W-1:0]          chan_cnt_ff, chan_cnt_in;
   logic [SSUM_W-1:0]          ssum_ff, ssum_in;
   logic [MAG_W-1:0]           max_mag_ff, max_mag_in;
   logic [TP_W-1:0]            tp_ff, tp_in;

   // Per-item work registers.
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [IDX_W-1:0]           k_ff, k_in;
   logic                       closes_ff, closes_in, last_ff, last_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic signed [SAMPLE_W-1:0] w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in;
   logic                       seg_sel_ff, seg_sel_in, seg2_pend_ff, seg2_pend_in;
   seg_coef_type               seg_ff, seg_in;

   // End-of-block work registers.
   logic [ONE_W-1:0]   r_ff, r_in;
   logic [COEFF_W-1:0] base_ff, base_in;
   logic [BLEN_W-1:0]  exp_ff, exp_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   logic               pow_vu_ff, pow_vu_in;
   logic [DIV_W-1:0]   divisor_ff, divisor_in, rem_ff, rem_in;
   logic [5:0]         iter_ff, iter_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [SREM_W-1:0]  srem_ff, srem_in;
   logic [55:0]        t1_ff, t1_in;
   logic [1:0]         db_sel_ff, db_sel_in;
   logic [MUL_W-1:0]   db_m_ff, db_m_in;
   logic [4:0]         db_e_ff, db_e_in;
   logic [15:0]        db_frac_ff, db_frac_in;
   logic [3:0]         db_i_ff, db_i_in;
   logic signed [DB_W-1:0] db_peak_ff, db_peak_in, db_tp_ff, db_tp_in, db_vu_ff, db_vu_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // The shared multiplier.
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] mul_p;
   logic [2*MUL_W-1:0] mul_q24;

   // Helpers.
   logic [TP_W-1:0]            interp_mag;
   logic [BLEN_W-1:0]          n_eff;
   logic [CHAN_W-1:0]          c_eff;
   logic signed [27:0]         y0e, y1e, y2e, y3e;
   logic [SSUM_W:0]            ssum_add;
   logic [DIV_W:0]             rem_sh;
   logic [SREM_W+1:0]          srem_sh, sqrt_trial;
   logic [57:0]                vu_sum;
   logic [MUL_W-1:0]           db_level, db_m2;
   logic signed [5:0]          lg_int;
   logic signed [21:0]         lg_v;
   logic [21:0]                lg_abs;
   logic [17:0]                db_rr;
   logic signed [18:0]         db_sv;
   logic signed [DB_W-1:0]     db_store_val;
   logic                       db_store;

   almtp_interp u_interp (
      .seg_i    (seg_ff),
      .tp_mag_o (interp_mag)
   );

   assign n_eff = (blk_len_ff == '0) ? BLEN_W'(1) : blk_len_ff;
   assign c_eff = (chan_cnt_ff == '0) ? CHAN_W'(1) : chan_cnt_ff;

   // The log2 fraction is built in Q16 under the integer part msb - 23.
   assign lg_int = $signed({1'b0, db_e_ff}) - 6'sd23;
   assign lg_v   = $signed({lg_int, db_frac_ff});
   assign lg_abs = lg_v[21] ? $unsigned(-lg_v) : $unsigned(lg_v);

   // Operand selection for the multiplier; one product is used per cycle.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQ: begin
            mul_a = MUL_W'(mag_ff);
            mul_b = MUL_W'(mag_ff);
         end
         ST_POWR: begin
            mul_a = MUL_W'(r_ff);
            mul_b = MUL_W'(base_ff);
         end
         ST_POWB: begin
            mul_a = MUL_W'(base_ff);
            mul_b = MUL_W'(base_ff);
         end
         ST_PEAK: begin
            mul_a = MUL_W'(peak_env_ff);
            mul_b = MUL_W'(r_ff);
         end
         ST_VU1: begin
            mul_a = vu_env_ff;
            mul_b = MUL_W'(r_ff);
         end
         ST_VU2: begin
            mul_a = root_ff;
            mul_b = MUL_W'(Q24_ONE - r_ff);
         end
         ST_DBSQ: begin
            mul_a = db_m_ff;
            mul_b = db_m_ff;
         end
         ST_DBSC: begin
            mul_a = MUL_W'(lg_abs);
            mul_b = DB_SCALE_Q16;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p   = mul_a * mul_b;
      mul_q24 = (mul_p + 64'h80_0000) >> 24;
   end

   always_comb begin
      // Hold everything by default.
      state_in      = state_ff;
      peak_coeff_in = peak_coeff_ff;
      vu_coeff_in   = vu_coeff_ff;
      clip_cfg_in   = clip_cfg_ff;
      peak_env_in   = peak_env_ff;
      vu_env_in     = vu_env_ff;
      clip_cnt_in   = clip_cnt_ff;
      hist0_in      = hist0_ff;
      hist1_in      = hist1_ff;
      hist2_in      = hist2_ff;
      idx_in        = idx_ff;
      blk_len_in    = blk_len_ff;
      chan_cnt_in   = chan_cnt_ff;
      ssum_in       = ssum_ff;
      max_mag_in    = max_mag_ff;
      tp_in         = tp_ff;
      x_in          = x_ff;
      mag_in        = mag_ff;
      k_in          = k_ff;
      closes_in     = closes_ff;
      last_in       = last_ff;
      sq_in         = sq_ff;
      w0_in         = w0_ff;
      w1_in         = w1_ff;
      w2_in         = w2_ff;
      w3_in         = w3_ff;
      seg_sel_in    = seg_sel_ff;
      seg2_pend_in  = seg2_pend_ff;
      seg_in        = seg_ff;
      r_in          = r_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      bit_cnt_in    = bit_cnt_ff;
      pow_vu_in     = pow_vu_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      iter_in       = iter_ff;
      root_in       = root_ff;
      srem_in       = srem_ff;
      t1_in         = t1_ff;
      db_sel_in     = db_sel_ff;
      db_m_in       = db_m_ff;
      db_e_in       = db_e_ff;
      db_frac_in    = db_frac_ff;
      db_i_in       = db_i_ff;
      db_peak_in    = db_peak_ff;
      db_tp_in      = db_tp_ff;
      db_vu_in      = db_vu_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;

      ssum_add     = {1'b0, ssum_ff} + (SSUM_W+1)'(sq_ff);
      rem_sh       = {rem_ff, ssum_ff[SSUM_W-1]};
      srem_sh      = {srem_ff, ssum_ff[SSUM_W-1:SSUM_W-2]};
      sqrt_trial   = (SREM_W+2)'({root_ff, 2'b01});
      vu_sum       = 58'(t1_ff) + 58'(mul_p) + 58'h80_0000;
      db_m2        = mul_p[61:30];
      db_rr        = 18'((mul_p + 64'h8000_0000) >> 32);
      db_sv        = lg_v[21] ? -$signed({1'b0, db_rr}) : $signed({1'b0, db_rr});
      db_store     = 1'b0;
      db_store_val = DB_FLOOR;
      y0e          = '0;
      y1e          = '0;
      y2e          = '0;
      y3e          = '0;

      unique case (db_sel_ff)
         DB_SEL_PEAK: db_level = MUL_W'(peak_env_ff);
         DB_SEL_TP:   db_level = MUL_W'(tp_ff);
         DB_SEL_VU:   db_level = vu_env_ff;
         default:     db_level = '0;
      endcase

      // The user must make configuration writes only while the block is idle; the block does not enforce this.
      if (csr_we) begin
         unique case (csr_index)
            CSR_PEAK_COEFF: peak_coeff_in = COEFF_W'(csr_wdata);
            CSR_VU_COEFF:   vu_coeff_in   = COEFF_W'(csr_wdata);
            CSR_CLIP_HOLD:  clip_cfg_in   = CLIP_W'(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Take the item and advance the channel and block counters at once.
               x_in      = req_data.sample;
               mag_in    = req_data.sample[SAMPLE_W-1] ? $unsigned(-req_data.sample)
                                                       : $unsigned(req_data.sample);
               k_in      = idx_ff;
               closes_in = req_data.last_of_channel | req_data.last_of_block;
               last_in   = req_data.last_of_block;
               if (req_data.last_of_channel || req_data.last_of_block) begin
                  if (chan_cnt_ff == '0) begin
                     blk_len_in = BLEN_W'(idx_ff) + BLEN_W'(1);
                  end
                  if (chan_cnt_ff < CHAN_W'(MAX_CHANNELS)) begin
                     chan_cnt_in = chan_cnt_ff + CHAN_W'(1);
                  end
                  idx_in = '0;
               end else if (idx_ff < IDX_W'(MAX_BLOCK_SAMPLES - 1)) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
               state_in = ST_SQ;
            end
         end

         ST_SQ: begin
            sq_in    = SQ_W'(mul_p);
            state_in = ST_ACC;
         end

         ST_ACC: begin
            ssum_in = ssum_add[SSUM_W] ? '1 : ssum_add[SSUM_W-1:0];
            if (mag_ff > max_mag_ff) begin
               max_mag_in = mag_ff;
            end
            if (TP_W'(mag_ff) > tp_ff) begin
               tp_in = TP_W'(mag_ff);
            end
            // Window of the last three samples and this one for the segments.
            w0_in = hist2_ff;
            w1_in = hist1_ff;
            w2_in = hist0_ff;
            w3_in = x_ff;
            if (k_ff == '0) begin
               hist0_in = x_ff;
               hist1_in = x_ff;
               hist2_in = x_ff;
            end else begin
               hist2_in = hist1_ff;
               hist1_in = hist0_ff;
               hist0_in = x_ff;
            end
            // The power step is primed here in case this item ends the block.
            r_in       = Q24_ONE;
            base_in    = peak_coeff_ff;
            exp_in     = n_eff;
            bit_cnt_in = '0;
            pow_vu_in  = 1'b0;
            if (k_ff >= IDX_W'(2)) begin
               seg_sel_in   = 1'b0;
               seg2_pend_in = closes_ff;
               state_in     = ST_SEGA;
            end else if (closes_ff && (k_ff != '0)) begin
               seg_sel_in   = 1'b1;
               seg2_pend_in = 1'b0;
               state_in     = ST_SEGA;
            end else if (last_ff) begin
               state_in = ST_POWR;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SEGA: begin
            // The closing segment repeats the final sample at the channel edge.
            if (seg_sel_ff) begin
               y0e = 28'(w1_ff);
               y1e = 28'(w2_ff);
               y2e = 28'(w3_ff);
               y3e = 28'(w3_ff);
            end else begin
               y0e = 28'(w0_ff);
               y1e = 28'(w1_ff);
               y2e = 28'(w2_ff);
               y3e = 28'(w3_ff);
            end
            seg_in.a0 = -y0e + (y1e * 28'sd3) - (y2e * 28'sd3) + y3e;
            seg_in.a1 = (y0e * 28'sd2) - (y1e * 28'sd5) + (y2e * 28'sd4) - y3e;
            seg_in.a2 = 26'(y2e - y0e);
            seg_in.y1 = SAMPLE_W'(y1e);
            seg_in.k  = INTERP_T1;
            state_in  = ST_SEGK;
         end

         ST_SEGK: begin
            if (interp_mag > tp_ff) begin
               tp_in = interp_mag;
            end
            if (seg_ff.k == INTERP_T3) begin
               if (seg2_pend_ff) begin
                  seg_sel_in   = 1'b1;
                  seg2_pend_in = 1'b0;
                  state_in     = ST_SEGA;
               end else if (last_ff) begin
                  state_in = ST_POWR;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               seg_in.k = seg_ff.k + 2'd1;
            end
         end

         ST_POWR: begin
            if (exp_ff[0]) begin
               r_in = ONE_W'(mul_q24);
            end
            state_in = ST_POWB;
         end

         ST_POWB: begin
            base_in    = COEFF_W'(mul_q24);
            exp_in     = exp_ff >> 1;
            bit_cnt_in = bit_cnt_ff + 4'd1;
            state_in   = ST_POWR;
            if (bit_cnt_ff == 4'(BLEN_W - 1)) begin
               if (pow_vu_ff) begin
                  divisor_in = DIV_W'(n_eff) * DIV_W'(c_eff);
                  rem_in     = '0;
                  iter_in    = '0;
                  state_in   = ST_DIV;
               end else begin
                  state_in = ST_PEAK;
               end
            end
         end

         ST_PEAK: begin
            if (max_mag_ff > peak_env_ff) begin
               peak_env_in = max_mag_ff;
            end else begin
               peak_env_in = MAG_W'(mul_q24);
            end
            if (tp_ff >= CLIP_THRESHOLD) begin
               clip_cnt_in = clip_cfg_ff;
            end else if (clip_cnt_ff > CLIP_W'(n_eff)) begin
               clip_cnt_in = clip_cnt_ff - CLIP_W'(n_eff);
            end else begin
               clip_cnt_in = '0;
            end
            r_in       = Q24_ONE;
            base_in    = vu_coeff_ff;
            exp_in     = n_eff;
            bit_cnt_in = '0;
            pow_vu_in  = 1'b1;
            state_in   = ST_POWR;
         end

         ST_DIV: begin
            // Restoring divide; the quotient shifts into the sum register.
            if (rem_sh >= {1'b0, divisor_ff}) begin
               rem_in  = DIV_W'(rem_sh - {1'b0, divisor_ff});
               ssum_in = {ssum_ff[SSUM_W-2:0], 1'b1};
            end else begin
               rem_in  = DIV_W'(rem_sh);
               ssum_in = {ssum_ff[SSUM_W-2:0], 1'b0};
            end
            iter_in = iter_ff + 6'd1;
            if (iter_ff == 6'd63) begin
               root_in  = '0;
               srem_in  = '0;
               iter_in  = '0;
               state_in = ST_SQRT;
            end
         end

         ST_SQRT: begin
            // Two bits of the quotient per step, one root bit out.
            if (srem_sh >= sqrt_trial) begin
               srem_in = SREM_W'(srem_sh - sqrt_trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = SREM_W'(srem_sh);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            ssum_in = {ssum_ff[SSUM_W-3:0], 2'b00};
            iter_in = iter_ff + 6'd1;
            if (iter_ff == 6'd31) begin
               state_in = ST_VU1;
            end
         end

         ST_VU1: begin
            t1_in    = 56'(mul_p);
            state_in = ST_VU2;
         end

         ST_VU2: begin
            vu_env_in = VU_W'(vu_sum >> 24);
            db_sel_in = DB_SEL_PEAK;
            state_in  = ST_DBLD;
         end

         ST_DBLD: begin
            if (db_level == '0) begin
               db_store = 1'b1;
            end else begin
               db_m_in  = db_level;
               db_e_in  = 5'd30;
               state_in = ST_DBNRM;
            end
         end

         ST_DBNRM: begin
            // Bring the level into [2^30, 2^31) one bit per cycle.
            if (db_m_ff[MUL_W-1]) begin
               db_m_in = db_m_ff >> 1;
               db_e_in = db_e_ff + 5'd1;
            end else if (!db_m_ff[MUL_W-2]) begin
               db_m_in = db_m_ff << 1;
               db_e_in = db_e_ff - 5'd1;
            end else begin
               db_frac_in = '0;
               db_i_in    = 4'd15;
               state_in   = ST_DBSQ;
            end
         end

         ST_DBSQ: begin
            if (db_m2[MUL_W-1]) begin
               db_m_in             = db_m2 >> 1;
               db_frac_in[db_i_ff] = 1'b1;
            end else begin
               db_m_in = db_m2;
            end
            db_i_in = db_i_ff - 4'd1;
            if (db_i_ff == 4'd0) begin
               state_in = ST_DBSC;
            end
         end

         ST_DBSC: begin
            db_store = 1'b1;
            if (db_sv < 19'(DB_FLOOR)) begin
               db_store_val = DB_FLOOR;
            end else if (db_sv > 19'(DB_CEIL)) begin
               db_store_val = DB_CEIL;
            end else begin
               db_store_val = DB_W'(db_sv);
            end
         end

         ST_DONE: begin
            // Hand over once the output register is free, then open a new block.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.peak_level_db      = db_peak_ff;
               rsp_data_in.true_peak_level_db = db_tp_ff;
               rsp_data_in.vu_level_db        = db_vu_ff;
               rsp_data_in.clip_hold_left     = clip_cnt_ff;
               ssum_in     = '0;
               max_mag_in  = '0;
               tp_in       = '0;
               idx_in      = '0;
               blk_len_in  = '0;
               chan_cnt_in = '0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A finished conversion lands in its slot and the next level follows.
      if (db_store) begin
         unique case (db_sel_ff)
            DB_SEL_PEAK: db_peak_in = db_store_val;
            DB_SEL_TP:   db_tp_in   = db_store_val;
            default:     db_vu_in   = db_store_val;
         endcase
         if (db_sel_ff == DB_SEL_VU) begin
            state_in = ST_DONE;
         end else begin
            db_sel_in = db_sel_ff + 2'd1;
            state_in  = ST_DBLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         peak_coeff_ff <= PEAK_COEFF_RESET;
         vu_coeff_ff   <= VU_COEFF_RESET;
         clip_cfg_ff   <= CLIP_HOLD_RESET;
         peak_env_ff   <= '0;
         vu_env_ff     <= '0;
         clip_cnt_ff   <= '0;
         hist0_ff      <= '0;
         hist1_ff      <= '0;
         hist2_ff      <= '0;
         idx_ff        <= '0;
         blk_len_ff    <= '0;
         chan_cnt_ff   <= '0;
         ssum_ff       <= '0;
         max_mag_ff    <= '0;
         tp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         peak_coeff_ff <= peak_coeff_in;
         vu_coeff_ff   <= vu_coeff_in;
         clip_cfg_ff   <= clip_cfg_in;
         peak_env_ff   <= peak_env_in;
         vu_env_ff     <= vu_env_in;
         clip_cnt_ff   <= clip_cnt_in;
         hist0_ff      <= hist0_in;
         hist1_ff      <= hist1_in;
         hist2_ff      <= hist2_in;
         idx_ff        <= idx_in;
         blk_len_ff    <= blk_len_in;
         chan_cnt_ff   <= chan_cnt_in;
         ssum_ff       <= ssum_in;
         max_mag_ff    <= max_mag_in;
         tp_ff         <= tp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      mag_ff       <= mag_in;
      k_ff         <= k_in;
      closes_ff    <= closes_in;
      last_ff      <= last_in;
      sq_ff        <= sq_in;
      w0_ff        <= w0_in;
      w1_ff        <= w1_in;
      w2_ff        <= w2_in;
      w3_ff        <= w3_in;
      seg_sel_ff   <= seg_sel_in;
      seg2_pend_ff <= seg2_pend_in;
      seg_ff       <= seg_in;
      r_ff         <= r_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      bit_cnt_ff   <= bit_cnt_in;
      pow_vu_ff    <= pow_vu_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      iter_ff      <= iter_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      t1_ff        <= t1_in;
      db_sel_ff    <= db_sel_in;
      db_m_ff      <= db_m_in;
      db_e_ff      <= db_e_in;
      db_frac_ff   <= db_frac_in;
      db_i_ff      <= db_i_in;
      db_peak_ff   <= db_peak_in;
      db_tp_ff     <= db_tp_in;
      db_vu_ff     <= db_vu_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // The block takes an item only between items; results wait in the output
   // register while the next samples of the new block come in.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for audio_level_meter_true_peak_core.
// Depends on rtl/almtp_pkg.sv and the core; holds its own meter predictor.
`timescale 1ns / 100ps

module testbench;
   import almtp_pkg::*;

   // The register index that the core must ignore.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;
   // Drain time covers the slowest block end plus the last sample's own work.
   localparam int DRAIN_CYCLES = 400;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   audio_level_meter_true_peak_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected readings, oldest first, and the failure tally.
   rsp_payload_type pending_readings[$];
   int fails = 0;
   int items_sent = 0;
   int cycles = 0;
   bit hold_off_req = 0;

   // Predictor copy of the meter registers and state.
   longint unsigned m_peak_coeff, m_vu_coeff, m_clip_samples;
   longint unsigned m_peak_env, m_vu_env, m_clip_count;
   longint m_hist[3];
   int unsigned m_index, m_blen, m_chans;
   longint unsigned m_sqsum, m_max_mag, m_true_peak;

   function automatic longint unsigned q24_product(longint unsigned a, longint unsigned b);
      return (a * b + 64'd8388608) >> 24;
   endfunction

   // Coefficient raised to n, square and multiply from the low bit.
   function automatic longint unsigned coeff_power(longint unsigned c, int unsigned n);
      longint unsigned r, base;
      r = 64'd1 << 24;
      base = c;
      while (n != 0) begin
         if (n[0]) r = q24_product(r, base);
         base = q24_product(base, base);
         n = n >> 1;
      end
      return r;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void note_peak(longint unsigned m);
      longint unsigned cap;
      cap = (64'd1 << TP_W) - 1;
      if (m > cap) m = cap;
      if (m > m_true_peak) m_true_peak = m;
   endfunction

   // Catmull-Rom interpolants at quarter steps between y1 and y2, in 1/128 units.
   function automatic void interp_segment(longint y0, longint y1, longint y2, longint y3);
      longint a0, a1, a2, v;
      longint unsigned m;
      a0 = -y0 + 3 * y1 - 3 * y2 + y3;
      a1 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      a2 = y2 - y0;
      for (longint k = 1; k <= 3; k++) begin
         v = a0 * k * k * k + 4 * a1 * k * k + 16 * a2 * k + 128 * y1;
         m = (v < 0) ? longint'(-v) : v;
         note_peak((m + 64) >> 7);
      end
   endfunction

   function automatic logic signed [DB_W-1:0] level_to_db(longint unsigned level);
      int msb;
      longint unsigned m, scale;
      longint lg, r;
      if (level == 0) return DB_FLOOR;
      scale = DB_SCALE_Q16;
      msb = 0;
      while (msb < 63 && (level >> (msb + 1)) != 0) msb++;
      m = (msb <= 30) ? level << (30 - msb) : level >> (msb - 30);
      lg = longint'(msb - (SAMPLE_W - 1)) * 65536;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            lg = lg + (longint'(1) << i);
         end
      end
      if (lg < 0) r = -longint'((longint'(-lg) * scale + (64'd1 << 31)) >> 32);
      else r = longint'((longint'(lg) * scale + (64'd1 << 31)) >> 32);
      if (r < DB_FLOOR) r = DB_FLOOR;
      if (r > DB_CEIL) r = DB_CEIL;
      return r[DB_W-1:0];
   endfunction

   function automatic void meter_reset();
      m_peak_coeff = PEAK_COEFF_RESET;
      m_vu_coeff = VU_COEFF_RESET;
      m_clip_samples = CLIP_HOLD_RESET;
      m_peak_env = 0; m_vu_env = 0; m_clip_count = 0;
      m_hist[0] = 0; m_hist[1] = 0; m_hist[2] = 0;
      m_index = 0; m_blen = 0; m_chans = 0;
      m_sqsum = 0; m_max_mag = 0; m_true_peak = 0;
   endfunction

   // Advances the predictor by one sample; returns 1 with the readings at a block end.
   function automatic bit meter_step(req_payload_type item, output rsp_payload_type rd);
      longint x;
      longint unsigned mag, sq, n, c, rms, g;
      bit closes;
      int unsigned k;
      x = item.sample;
      mag = (x < 0) ? longint'(-x) : x;
      sq = mag * mag;
      closes = item.last_of_channel || item.last_of_block;
      k = m_index;
      rd = '0;

      m_sqsum = (m_sqsum > ~64'd0 - sq) ? ~64'd0 : m_sqsum + sq;
      if (mag > m_max_mag) m_max_mag = mag;
      note_peak(mag);

      if (k == 0) begin
         m_hist[0] = x; m_hist[1] = x; m_hist[2] = x;
      end else begin
         if (k >= 2) interp_segment(m_hist[2], m_hist[1], m_hist[0], x);
         if (closes) interp_segment(m_hist[1], m_hist[0], x, x);
         m_hist[2] = m_hist[1];
         m_hist[1] = m_hist[0];
         m_hist[0] = x;
      end

      if (closes) begin
         if (m_chans == 0) m_blen = k + 1;
         if (m_chans < MAX_CHANNELS) m_chans++;
         m_index = 0;
      end else if (k < MAX_BLOCK_SAMPLES - 1) begin
         m_index = k + 1;
      end

      if (!item.last_of_block) return 0;

      n = (m_blen != 0) ? m_blen : 1;
      c = (m_chans != 0) ? m_chans : 1;
      if (m_max_mag > m_peak_env) m_peak_env = m_max_mag;
      else m_peak_env = q24_product(m_peak_env, coeff_power(m_peak_coeff, n));
      rms = int_sqrt(m_sqsum / (n * c));
      g = coeff_power(m_vu_coeff, n);
      m_vu_env = (g * m_vu_env + ((64'd1 << 24) - g) * rms + 64'd8388608) >> 24;
      if (m_true_peak >= CLIP_THRESHOLD) m_clip_count = m_clip_samples;
      else m_clip_count = (m_clip_count > n) ? m_clip_count - n : 0;

      rd.peak_level_db = level_to_db(m_peak_env);
      rd.true_peak_level_db = level_to_db(m_true_peak);
      rd.vu_level_db = level_to_db(m_vu_env);
      rd.clip_hold_left = m_clip_count[CLIP_W-1:0];

      m_sqsum = 0; m_max_mag = 0; m_true_peak = 0;
      m_index = 0; m_blen = 0; m_chans = 0;
      return 1;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender. Items go out in bursts with random gaps between them; some bursts
   // carry no gaps at all. Each accepted item steps the predictor right away.
   // ---------------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_item(req_payload_type item, bit typed, rsp_payload_type typed_rd);
      rsp_payload_type rd;
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (meter_step(item, rd)) pending_readings.push_back(typed ? typed_rd : rd);
   endtask

   task automatic send_plain(logic signed [SAMPLE_W-1:0] s, bit loc, bit lob);
      req_payload_type item;
      item.sample = s;
      item.last_of_channel = loc;
      item.last_of_block = lob;
      send_item(item, 1'b0, '0);
   endtask

   // Lets the core go idle: every reading back, then the longest block-end time.
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      wait (pending_readings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(negedge clock) csr_we <= 1'b0;
      case (idx)
         CSR_PEAK_COEFF: m_peak_coeff = value & 64'hFF_FFFF;
         CSR_VU_COEFF:   m_vu_coeff = value & 64'hFF_FFFF;
         CSR_CLIP_HOLD:  m_clip_samples = value & 64'hF_FFFF;
         default: ;
      endcase
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
         3: return '0;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // One well-formed block: nch channels, the first of length n. Others may differ,
   // and the block may end without its last channel end flag.
   task automatic send_block(int nch, int n);
      int len;
      bit drop_loc;
      drop_loc = ($urandom_range(0, 4) == 0);
      for (int ch = 0; ch < nch; ch++) begin
         len = (ch == 0 || $urandom_range(0, 3) != 0) ? n : $urandom_range(1, n + 4);
         for (int i = 0; i < len; i++) begin
            bit lob;
            lob = (ch == nch - 1) && (i == len - 1);
            send_plain(pick_sample(), (i == len - 1) && !(lob && drop_loc), lob);
         end
      end
   endtask

   // Directed rows; a typed reading is one that is plain from the definition.
   typedef struct {
      logic signed [SAMPLE_W-1:0] s;
      bit loc;
      bit lob;
      bit typed;
      rsp_payload_type want;
   } stim_row_type;

   stim_row_type directed_rows[$];

   task automatic add_row(logic signed [SAMPLE_W-1:0] s, bit loc, bit lob, bit typed = 0,
                          rsp_payload_type want = '0);
      stim_row_type r;
      r.s = s; r.loc = loc; r.lob = lob; r.typed = typed; r.want = want;
      directed_rows.push_back(r);
   endtask

   task automatic run_random_phase(int items_goal);
      while (items_sent < items_goal) begin
         case ($urandom_range(0, 9))
            0: begin
               // Noise: flags at random, block ends included now and then.
               send_plain(SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 5) == 0);
            end
            1: send_block($urandom_range(9, 11), $urandom_range(1, 3));
            default: send_block($urandom_range(1, 3), $urandom_range(1, 12));
         endcase
      end
      // Close whatever is open so the phase ends on a reading.
      send_plain(pick_sample(), 1'b1, 1'b1);
   endtask

   initial begin
      rsp_payload_type silent;
      int goal;
      meter_reset();
      silent.peak_level_db = DB_FLOOR;
      silent.true_peak_level_db = DB_FLOOR;
      silent.vu_level_db = DB_FLOOR;
      silent.clip_hold_left = '0;

      // Silence right after reset reads the floor everywhere.
      add_row('0, 1'b1, 1'b1, 1'b1, silent);
      // Full scale both ways, one sample per block.
      add_row(SAMPLE_MAX, 1'b1, 1'b1);
      add_row(SAMPLE_MIN, 1'b1, 1'b1);
      // Alternating full scale overshoots between samples; two channels.
      add_row(SAMPLE_MAX, 1'b0, 1'b0);
      add_row(SAMPLE_MIN, 1'b0, 1'b0);
      add_row(SAMPLE_MAX, 1'b0, 1'b0);
      add_row(SAMPLE_MIN, 1'b1, 1'b0);
      add_row(24'sd1000, 1'b0, 1'b0);
      add_row(-24'sd1000, 1'b1, 1'b1);
      // Block ended inside the first channel, without a channel end.
      add_row(24'sd5, 1'b0, 1'b0);
      add_row(-24'sd3, 1'b0, 1'b0);
      add_row(24'sd1, 1'b0, 1'b1);
      // Second channel longer than the first.
      add_row(24'sd4000000, 1'b1, 1'b0);
      add_row(-24'sd4000000, 1'b0, 1'b0);
      add_row(24'sd2000000, 1'b0, 1'b0);
      add_row(24'sd1, 1'b1, 1'b1);
      // Quiet blocks let the envelopes decay.
      add_row('0, 1'b1, 1'b1);
      add_row('0, 1'b0, 1'b0);
      add_row('0, 1'b1, 1'b1);

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i]) begin
         req_payload_type item;
         item.sample = directed_rows[i].s;
         item.last_of_channel = directed_rows[i].loc;
         item.last_of_block = directed_rows[i].lob;
         send_item(item, directed_rows[i].typed, directed_rows[i].want);
      end
      settle();

      // Extremes: no decay memory at all, a short clip hold, and an ignored index.
      write_reg(CSR_PEAK_COEFF, 0);
      write_reg(CSR_VU_COEFF, 0);
      write_reg(CSR_CLIP_HOLD, 5);
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      goal = items_sent + RANDOM_ITEMS / 5;
      run_random_phase(goal);

      // Pressure: the receiver holds off while small blocks keep coming.
      hold_off_req = 1;
      for (int i = 0; i < 30; i++) send_block(1, 1);
      settle();

      write_reg(CSR_PEAK_COEFF, 24'hFFFFFF);
      write_reg(CSR_VU_COEFF, 24'hFFFFFF);
      write_reg(CSR_CLIP_HOLD, 20'hFFFFF);
      goal = items_sent + RANDOM_ITEMS / 5;
      run_random_phase(goal);
      settle();

      write_reg(CSR_CLIP_HOLD, 0);
      write_reg(CSR_PEAK_COEFF, 24'h800000 ^ 24'($urandom()));
      write_reg(CSR_VU_COEFF, $urandom_range(0, 24'hFFFFFF));
      goal = items_sent + RANDOM_ITEMS / 5;
      run_random_phase(goal);
      settle();

      write_reg(CSR_PEAK_COEFF, PEAK_COEFF_RESET);
      write_reg(CSR_VU_COEFF, VU_COEFF_RESET);
      write_reg(CSR_CLIP_HOLD, $urandom_range(0, 20'hFFFFF));
      goal = items_sent + 2 * RANDOM_ITEMS / 5;
      run_random_phase(goal);

      @(negedge clock) req_valid <= 1'b0;
      wait (pending_readings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver. Ready follows its own stall pattern; on request it holds off for
   // a long stretch so the core backs up and stalls its input.
   // ---------------------------------------------------------------------------
   initial begin
      int stall_left, mode, mode_left;
      stall_left = 0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               case (mode)
                  1: stall_left = $urandom_range(0, 1);
                  2: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
                  3: stall_left = $urandom_range(0, 6);
                  default: stall_left = 0;
               endcase
            end
         end
      end
   end

   // Each reading taken is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $error("reading with none expected: %p", rsp_data);
            fails++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_data.peak_level_db !== want.peak_level_db) begin
               $error("peak_level_db expected %0d got %0d",
                      want.peak_level_db, rsp_data.peak_level_db);
               fails++;
            end
            if (rsp_data.true_peak_level_db !== want.true_peak_level_db) begin
               $error("true_peak_level_db expected %0d got %0d",
                      want.true_peak_level_db, rsp_data.true_peak_level_db);
               fails++;
            end
            if (rsp_data.vu_level_db !== want.vu_level_db) begin
               $error("vu_level_db expected %0d got %0d",
                      want.vu_level_db, rsp_data.vu_level_db);
               fails++;
            end
            if (rsp_data.clip_hold_left !== want.clip_hold_left) begin
               $error("clip_hold_left expected %0d got %0d",
                      want.clip_hold_left, rsp_data.clip_hold_left);
               fails++;
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

endmodule
